// ----- design/mlns_pkg.sv -----
// ----------------------------------------------------------------------------
// mlns_pkg
// Shared types and codes for the last-note-priority note stack.
// ----------------------------------------------------------------------------
package mlns_pkg;

	localparam int NOTE_W = 7;
	localparam int VEL_W  = 7;
	localparam int CIN_W  = 4;

	localparam logic [CIN_W-1:0] CIN_NOTE_OFF = 4'd8;
	localparam logic [CIN_W-1:0] CIN_NOTE_ON  = 4'd9;

	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
	} entry_t;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN     = 6'b000010,
		ST_SHIFT    = 6'b000100,
		ST_RD_TOP   = 6'b001000,
		ST_WAIT_TOP = 6'b010000,
		ST_DONE     = 6'b100000
	} state_t;

endpackage

// ----- design/mlns_mem.sv -----
// ----------------------------------------------------------------------------
// mlns_mem
// Stack entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mlns_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  mlns_pkg::entry_t wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output mlns_pkg::entry_t rdata
);
	import mlns_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/midi_last_note_stack.sv -----
// ----------------------------------------------------------------------------
// midi_last_note_stack
// Last-note-priority stack of held MIDI notes, kept in one entry memory.
// ----------------------------------------------------------------------------
// One request is in work at a time; every request yields one result. The
// stack is a circular buffer in a memory with a single read port and
// registered read data. A note on, or any request on an empty stack, goes
// straight to its result. An ignored request on a non-empty stack re-reads
// the top entry. A note off scans down from the top one entry per cycle,
// then moves the entries above the match down one place, one per cycle,
// and re-reads the new top entry unless the stack ends empty; when no
// entry matches, it re-reads the top entry.
// A push onto a full stack advances the buffer base and overwrites the
// oldest entry, so it costs no more than any other push.
// ----------------------------------------------------------------------------
module midi_last_note_stack #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [mlns_pkg::CIN_W-1:0] code_index,
	input  logic [mlns_pkg::NOTE_W-1:0] note_number,
	input  logic [mlns_pkg::VEL_W-1:0] velocity,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       gate,
	output logic [mlns_pkg::NOTE_W-1:0] top_note,
	output logic [mlns_pkg::VEL_W-1:0] top_velocity,
	output logic                       overflow
);
	import mlns_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [AW-1:0] i);
		logic [AW:0] s;
		s = {1'b0, b} + {1'b0, i};
		if (s >= (AW+1)'(STACK_DEPTH)) begin
			s = s - (AW+1)'(STACK_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] base_q;
	logic          out_valid_q;

	logic [NOTE_W-1:0] note_q;
	logic [AW-1:0]     scan_idx_q;
	logic              iss_left_q;
	logic [AW-1:0]     chk_idx_s1;
	logic              chk_vld_s1;
	logic [CW-1:0]     sh_rd_q;
	logic [AW-1:0]     sh_wr_s1;
	logic              sh_wv_s1;

	logic              res_gate_q;
	entry_t            res_top_q;
	logic              res_ovf_q;

	logic              gate_q;
	entry_t            top_q;
	logic              ovf_q;

	logic          accept;
	logic          full;
	logic [CW-1:0] count_dec;
	logic [AW-1:0] top_idx;
	logic          hit;
	logic          sh_issue;
	logic          out_free;

	logic          mem_we;
	logic [AW-1:0] wr_idx;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] rd_idx;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign count_dec = count_q - CW'(1);
	assign top_idx   = count_dec[AW-1:0];
	assign hit       = chk_vld_s1 && (mem_rdata.note == note_q);
	assign sh_issue  = (sh_rd_q < count_q);
	assign out_free  = !out_valid_q || out_ready;

	// memory port steering
	always_comb begin
		mem_we    = 1'b0;
		wr_idx    = '0;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		rd_idx    = top_idx;
		case (state_q)
			ST_IDLE: begin
				if (accept && code_index == CIN_NOTE_ON) begin
					mem_we    = 1'b1;
					wr_idx    = full ? '0 : count_q[AW-1:0];
					mem_wdata = '{note: note_number, vel: velocity};
				end
			end
			ST_SCAN: begin
				rd_idx = scan_idx_q;
				if (!hit && !(chk_vld_s1 && chk_idx_s1 == '0)) begin
					mem_re = iss_left_q;
				end
			end
			ST_SHIFT: begin
				rd_idx = sh_rd_q[AW-1:0];
				mem_re = sh_issue;
				mem_we = sh_wv_s1;
				wr_idx = sh_wr_s1;
			end
			ST_RD_TOP: begin
				mem_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign mem_waddr = phys(base_q, wr_idx);
	assign mem_raddr = phys(base_q, rd_idx);

	mlns_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
			iss_left_q  <= 1'b0;
			chk_vld_s1  <= 1'b0;
			sh_wv_s1    <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (code_index == CIN_NOTE_ON) begin
							if (full) begin
								base_q <= (base_q == AW'(STACK_DEPTH - 1)) ? '0 : base_q + AW'(1);
							end else begin
								count_q <= count_q + CW'(1);
							end
							state_q <= ST_DONE;
						end else if (count_q == '0) begin
							state_q <= ST_DONE;
						end else if (code_index == CIN_NOTE_OFF) begin
							iss_left_q <= 1'b1;
							chk_vld_s1 <= 1'b0;
							state_q    <= ST_SCAN;
						end else begin
							state_q <= ST_RD_TOP;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						sh_wv_s1 <= 1'b0;
						state_q  <= ST_SHIFT;
					end else if (chk_vld_s1 && chk_idx_s1 == '0) begin
						state_q <= ST_RD_TOP;
					end else begin
						chk_vld_s1 <= iss_left_q;
						if (iss_left_q && scan_idx_q == '0) begin
							iss_left_q <= 1'b0;
						end
					end
				end
				ST_SHIFT: begin
					sh_wv_s1 <= sh_issue;
					if (!sh_issue && !sh_wv_s1) begin
						count_q <= count_dec;
						state_q <= (count_dec == '0) ? ST_DONE : ST_RD_TOP;
					end
				end
				ST_RD_TOP: begin
					state_q <= ST_WAIT_TOP;
				end
				ST_WAIT_TOP: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					note_q     <= note_number;
					scan_idx_q <= top_idx;
					res_ovf_q  <= (code_index == CIN_NOTE_ON) && full;
					if (code_index == CIN_NOTE_ON) begin
						res_gate_q <= 1'b1;
						res_top_q  <= '{note: note_number, vel: velocity};
					end else begin
						res_gate_q <= 1'b0;
						res_top_q  <= '0;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					sh_rd_q <= CW'(chk_idx_s1) + CW'(1);
				end else if (iss_left_q) begin
					chk_idx_s1 <= scan_idx_q;
					scan_idx_q <= scan_idx_q - AW'(1);
				end
			end
			ST_SHIFT: begin
				sh_wr_s1 <= sh_rd_q[AW-1:0] - AW'(1);
				if (sh_issue) begin
					sh_rd_q <= sh_rd_q + CW'(1);
				end
				if (!sh_issue && !sh_wv_s1) begin
					res_gate_q <= 1'b0;
					res_top_q  <= '0;
				end
			end
			ST_WAIT_TOP: begin
				res_gate_q <= 1'b1;
				res_top_q  <= mem_rdata;
			end
			ST_DONE: begin
				if (out_free) begin
					gate_q <= res_gate_q;
					top_q  <= res_top_q;
					ovf_q  <= res_ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign gate         = gate_q;
	assign top_note     = top_q.note;
	assign top_velocity = top_q.vel;
	assign overflow     = ovf_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("held count beyond stack depth");

	a_no_rw_same: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && mem_waddr == mem_raddr))
		else $error("read and write of the same entry in one cycle");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !gate |-> top_note == '0 && top_velocity == '0 && !overflow)
		else $error("empty result carries a note");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept && code_index == CIN_NOTE_ON && full |=> count_q == CW'(STACK_DEPTH))
		else $error("full push changed the held count");

endmodule

// ----- tb/midi_last_note_stack_tb.sv -----
// ----------------------------------------------------------------------------
// midi_last_note_stack_tb
// Self-checking bench for the last-note-priority note stack. A short table of
// directed requests runs first. Random note on, note off and ignored packets
// follow, with random idle bursts on both channels. Every result is compared
// field by field with a typed table row, else a behavioral stack model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_last_note_stack_tb;
	import mlns_pkg::*;

	localparam int STACK_DEPTH  = 16;
	localparam int PLAN_LEN     = 27;
	localparam int RANDOM_ITEMS = 1625;
	localparam int CALM_ITEMS   = 150;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 60;

	localparam logic [CIN_W-1:0] CIN_RESERVED    = 4'd0;
	localparam logic [CIN_W-1:0] CIN_CTRL_CHANGE = 4'd11;

	typedef struct packed {
		logic              gate;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
		logic              ovf;
	} voice_t;

	typedef struct packed {
		logic [CIN_W-1:0]  cin;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
		logic              typed;
		logic              w_gate;
		logic [NOTE_W-1:0] w_note;
		logic [VEL_W-1:0]  w_vel;
		logic              w_ovf;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CIN_W-1:0]  code_index = '0;
	logic [NOTE_W-1:0] note_number = '0;
	logic [VEL_W-1:0]  velocity = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              gate;
	logic [NOTE_W-1:0] top_note;
	logic [VEL_W-1:0]  top_velocity;
	logic              overflow;

	entry_t held_stack[$];
	voice_t voice_q[$];
	int     errors = 0;
	bit     calm = 1'b0;
	bit     gaps_on = 1'b1;
	int     stall_left = 0;
	int     rx_cycles = 0;
	int     quiet_cycles = 0;

	plan_row_t plan [PLAN_LEN] = '{
		'{CIN_RESERVED,    7'd0,   7'd0,   1'b1, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_OFF,    7'd60,  7'd100, 1'b1, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd127, 7'd127, 1'b1, 1'b1, 7'd127, 7'd127, 1'b0},
		'{CIN_NOTE_ON,     7'd0,   7'd0,   1'b1, 1'b1, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd127, 7'd5,   1'b1, 1'b1, 7'd127, 7'd5,   1'b0},
		'{CIN_NOTE_OFF,    7'd127, 7'd0,   1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_CTRL_CHANGE, 7'd127, 7'd127, 1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_OFF,    7'd42,  7'd0,   1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_OFF,    7'd0,   7'd127, 1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd1,   7'd64,  1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd2,   7'd32,  1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd4,   7'd16,  1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd8,   7'd8,   1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd16,  7'd4,   1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd32,  7'd2,   1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd64,  7'd1,   1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd85,  7'd42,  1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd42,  7'd85,  1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd100, 7'd1,   1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd7,   7'd120, 1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd99,  7'd99,  1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd50,  7'd60,  1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd60,  7'd50,  1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd70,  7'd70,  1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_ON,     7'd33,  7'd127, 1'b1, 1'b1, 7'd33,  7'd127, 1'b1},
		'{CIN_NOTE_OFF,    7'd127, 7'd0,   1'b0, 1'b0, 7'd0,   7'd0,   1'b0},
		'{CIN_NOTE_OFF,    7'd8,   7'd0,   1'b0, 1'b0, 7'd0,   7'd0,   1'b0}
	};

	midi_last_note_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.code_index(code_index),
		.note_number(note_number),
		.velocity(velocity),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gate(gate),
		.top_note(top_note),
		.top_velocity(top_velocity),
		.overflow(overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic apply_midi_event(input logic [CIN_W-1:0] cin, input logic [NOTE_W-1:0] nn,
			input logic [VEL_W-1:0] vv, output voice_t res);
		entry_t e;
		int     i;
		res = '0;
		if (cin == CIN_NOTE_ON) begin
			e.note = nn;
			e.vel = vv;
			if (held_stack.size() >= STACK_DEPTH) begin
				held_stack.delete(0);
				res.ovf = 1'b1;
			end
			held_stack.push_back(e);
		end else if (cin == CIN_NOTE_OFF) begin
			for (i = held_stack.size() - 1; i >= 0; i--) begin
				if (held_stack[i].note == nn) begin
					held_stack.delete(i);
					break;
				end
			end
		end
		if (held_stack.size() > 0) begin
			res.gate = 1'b1;
			res.note = held_stack[$].note;
			res.vel = held_stack[$].vel;
		end
	endtask

	task automatic send_request(input logic [CIN_W-1:0] cin, input logic [NOTE_W-1:0] nn,
			input logic [VEL_W-1:0] vv, input bit typed, input voice_t want);
		voice_t pred;
		in_valid <= 1'b1;
		code_index <= cin;
		note_number <= nn;
		velocity <= vv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_midi_event(cin, nn, vv, pred);
		voice_q.push_back(typed ? want : pred);
		if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	task automatic compare_field(input string what, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	// check results and drive out_ready
	always @(posedge clk) begin
		voice_t want;
		if (arst_n) begin
			rx_cycles <= rx_cycles + 1;
			if (out_valid && out_ready) begin
				if (voice_q.size() == 0) begin
					errors++;
					$display("%0t: result with no request waiting: gate %0d note %0d vel %0d",
						$time, gate, top_note, top_velocity);
				end else begin
					want = voice_q.pop_front();
					compare_field("gate", want.gate, gate);
					compare_field("top_note", want.note, top_note);
					compare_field("top_velocity", want.vel, top_velocity);
					compare_field("overflow", want.ovf, overflow);
				end
			end
			if (calm) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (rx_cycles[8] && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(0, 16);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("midi_last_note_stack regression: fail");
				$finish;
			end
		end
	end

	initial begin
		voice_t           want;
		logic [CIN_W-1:0]  cin;
		logic [NOTE_W-1:0] nn;
		logic [VEL_W-1:0]  vv;
		int               musical;
		int               on_share;
		int               pick;
		bit               paused;
		musical = 0;
		paused = 1'b0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < PLAN_LEN; k++) begin
			want.gate = plan[k].w_gate;
			want.note = plan[k].w_note;
			want.vel = plan[k].w_vel;
			want.ovf = plan[k].w_ovf;
			send_request(plan[k].cin, plan[k].note, plan[k].vel, plan[k].typed, want);
		end

		while (musical < RANDOM_ITEMS) begin
			calm = (musical >= RANDOM_ITEMS - CALM_ITEMS);
			gaps_on = ((musical / 100) % 3) != 2;
			if (!paused && musical >= RANDOM_ITEMS / 2) begin
				// hold off until every result is back
				paused = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (voice_q.size() != 0)
					@(posedge clk);
			end
			on_share = ((musical / 120) % 2 == 0) ? 55 : 30;
			pick = $urandom_range(0, 99);
			vv = 7'($urandom);
			if (pick < on_share) begin
				cin = CIN_NOTE_ON;
				if ($urandom_range(0, 3) == 0)
					nn = 7'($urandom);
				else
					nn = 7'(58 + $urandom_range(0, 11));
				musical++;
			end else if (pick < 92) begin
				cin = CIN_NOTE_OFF;
				if (held_stack.size() > 0 && $urandom_range(0, 3) != 0)
					nn = held_stack[$urandom_range(0, held_stack.size() - 1)].note;
				else
					nn = 7'($urandom);
				musical++;
			end else begin
				do
					cin = 4'($urandom);
				while (cin == CIN_NOTE_ON || cin == CIN_NOTE_OFF);
				nn = 7'($urandom);
				if ($urandom_range(0, 4) == 0) begin
					cin = CIN_RESERVED;
					nn = '0;
					vv = '0;
				end
				musical++;
			end
			send_request(cin, nn, vv, 1'b0, '0);
		end

		calm = 1'b1;
		in_valid <= 1'b0;
		while (voice_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0)
			$display("midi_last_note_stack regression: pass");
		else
			$display("midi_last_note_stack regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
design/mlns_pkg.sv
design/mlns_mem.sv
design/midi_last_note_stack.sv
tb/midi_last_note_stack_tb.sv
